[rtl/nqsts_pkg.sv]
// Shared types, constants and helpers for the note-queue square tone synth.
package nqsts_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int FADE_LEN    = 64;
  localparam int FADE_W      = $clog2(FADE_LEN + 1);

  localparam int FREQ_W   = 14;
  localparam int LEN_W    = 21;
  localparam int PHASE_W  = 32;
  localparam int AMP_W    = 15;
  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 7;
  localparam int HZ_W     = 16;
  localparam int MS_W     = 16;

  localparam logic [FREQ_W-1:0] MAX_HZ          = 14'd11025;
  // floor((2^32 - 1) / 22050)
  localparam logic [17:0]       PHASE_UNIT      = 18'd194783;
  // ms * 22050 / 1000 == (ms * LEN_MUL) >> LEN_SHIFT, exact for 16-bit ms
  localparam logic [25:0]       LEN_MUL         = 26'd46242202;
  localparam int                LEN_SHIFT       = 21;
  localparam logic [VOL_W-1:0]  VOL_MAX         = 7'd100;
  localparam logic [7:0]        AMP_PER_PERCENT = 8'd240;
  localparam logic [AMP_W-1:0]  AMP_RESET       = 15'd6000;

  localparam logic [1:0] FUNC_QUEUE  = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH  = 2'd2;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [LEN_W-1:0]  len;
  } note_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    logic  flush;
    note_t note;
  } queue_cmd_t;

  typedef struct packed {
    logic  empty;
    logic  full;
    note_t head;
  } queue_stat_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

endpackage

[rtl/nqsts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module nqsts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/nqsts_queue.sv]
// Note ring queue: pointers, note memory and a register copy of the head note.
module nqsts_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  nqsts_pkg::queue_cmd_t   cmd,
  output nqsts_pkg::queue_stat_t  stat,
  output logic                    busy_next
);
  import nqsts_pkg::*;

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [IDX_W-1:0] rd_addr;
  note_t            cur;
  note_t            ram_rd;
  note_t            byp_data;
  logic             byp_valid;
  note_t            second;
  logic             empty;

  assign empty = (head == tail);

  always_comb begin
    head_next = head;
    tail_next = tail;
    if (cmd.flush) begin
      head_next = tail;
    end else if (cmd.pop) begin
      head_next = next_slot(head);
    end
    if (cmd.push) begin
      tail_next = next_slot(tail);
    end
  end

  // memory is always read one slot past the head so a pop finds its successor ready
  assign rd_addr   = next_slot(head_next);
  assign second    = byp_valid ? byp_data : ram_rd;
  assign busy_next = (head_next != tail_next);

  assign stat.empty = empty;
  assign stat.full  = (next_slot(tail) == head);
  assign stat.head  = cur;

  nqsts_ram #(
    .WIDTH ($bits(note_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (tail),
    .wr_data (cmd.note),
    .rd_addr (rd_addr),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      byp_valid <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      byp_valid <= cmd.push && (tail == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= cmd.note;
    if (cmd.push && empty) begin
      cur <= cmd.note;
    end else if (cmd.pop) begin
      cur <= second;
    end
  end

endmodule

[rtl/nqsts_voice.sv]
// Square-wave voice: phase accumulator, play position and fade envelope.
module nqsts_voice (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   play,
  input  logic                                   flush,
  input  nqsts_pkg::note_t                       head,
  input  logic [nqsts_pkg::AMP_W-1:0]            amp_base,
  output logic signed [nqsts_pkg::SAMPLE_W-1:0]  sample,
  output logic                                   pop
);
  import nqsts_pkg::*;

  logic [LEN_W-1:0]         pos;
  logic [LEN_W-1:0]         pos_inc;
  logic [LEN_W-1:0]         left;
  logic [PHASE_W-1:0]       phase_acc;
  logic [PHASE_W-1:0]       phase_step;
  logic [PHASE_W-1:0]       phase_new;
  logic [FADE_W-1:0]        fade;
  logic                     fading;
  logic [AMP_W+FADE_W-1:0]  scaled;
  logic [AMP_W-1:0]         amp;
  logic                     tone;

  assign left    = head.len - pos;
  assign pos_inc = pos + 1'b1;
  assign pop     = play && (pos_inc >= head.len);
  assign tone    = (head.freq != '0);

  always_comb begin
    fading = 1'b1;
    fade   = '0;
    if (pos < LEN_W'(FADE_LEN)) begin
      fade = pos[FADE_W-1:0];
    end else if (left < LEN_W'(FADE_LEN)) begin
      fade = left[FADE_W-1:0];
    end else begin
      fading = 1'b0;
    end
  end

  assign scaled     = (AMP_W+FADE_W)'((amp_base * fade) / FADE_LEN);
  assign amp        = fading ? scaled[AMP_W-1:0] : amp_base;
  assign phase_step = PHASE_W'(head.freq) * PHASE_W'(PHASE_UNIT);
  assign phase_new  = phase_acc + phase_step;

  always_comb begin
    if (!tone) begin
      sample = '0;
    end else if (phase_new[PHASE_W-1]) begin
      sample = -$signed({1'b0, amp});
    end else begin
      sample = $signed({1'b0, amp});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      phase_acc <= '0;
    end else if (flush) begin
      pos <= '0;
    end else if (play) begin
      pos <= pop ? '0 : pos_inc;
      if (tone) begin
        phase_acc <= phase_new;
      end
    end
  end

endmodule

[rtl/note_queue_square_tone_synth.sv]
// Note-queue square tone synth top level: stream ports, volume and result register.
// One item per clock: each transfer on s_* is registered, processed from that register
// (queue update, phase step, fade) and its result lands in an output register, so a
// steady stream of items yields one result per cycle while m_tready is high. The queue
// holds up to 127 notes; notes are read from a block memory one slot ahead of the head.
// s_tuser selects the item: 0 queue a note, 1 produce a sample, 2 empty the queue.
// Volume writes on cfg_wr_en take effect on the next item and saturate at 100 percent.
module note_queue_square_tone_synth (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,   // volume_percent
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // note_hz[15:0], duration_ms[31:16]
  input  logic [1:0]  s_tuser,       // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata        // sample[15:0], accepted[16], busy_res[17], zero
);
  import nqsts_pkg::*;

  logic               in_valid;
  logic [1:0]         in_func;
  logic [HZ_W-1:0]    in_hz;
  logic [MS_W-1:0]    in_ms;
  logic               adv;
  logic [AMP_W-1:0]   amp_base;
  logic [VOL_W-1:0]   vol_sat;
  logic [25+MS_W:0]   len_prod;
  logic               note_req;
  logic               accepted;
  logic               play;
  logic               busy_next;
  logic               pop;
  logic signed [SAMPLE_W-1:0] voice_sample;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic               out_accepted;
  logic               out_busy;
  queue_cmd_t         cmd;
  queue_stat_t        stat;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func <= s_tuser;
      in_hz   <= s_tdata[15:0];
      in_ms   <= s_tdata[31:16];
    end
  end

  assign vol_sat = (cfg_wr_data > VOL_MAX) ? VOL_MAX : cfg_wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      amp_base <= AMP_RESET;
    end else if (cfg_wr_en) begin
      amp_base <= AMP_W'(vol_sat) * AMP_W'(AMP_PER_PERCENT);
    end
  end

  assign len_prod  = in_ms * LEN_MUL;
  assign note_req  = (in_func == FUNC_QUEUE) && (in_ms != '0);
  assign accepted  = !(note_req && stat.full);
  assign play      = adv && (in_func == FUNC_SAMPLE) && !stat.empty;

  assign cmd.push      = adv && note_req && !stat.full;
  assign cmd.pop       = pop;
  assign cmd.flush     = adv && (in_func == FUNC_FLUSH);
  assign cmd.note.freq = (in_hz > HZ_W'(MAX_HZ)) ? MAX_HZ : in_hz[FREQ_W-1:0];
  assign cmd.note.len  = len_prod[LEN_SHIFT +: LEN_W];

  nqsts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .busy_next (busy_next)
  );

  nqsts_voice u_voice (
    .clk      (clk),
    .rst      (rst),
    .play     (play),
    .flush    (cmd.flush),
    .head     (stat.head),
    .amp_base (amp_base),
    .sample   (voice_sample),
    .pop      (pop)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sample   <= play ? voice_sample : '0;
      out_accepted <= accepted;
      out_busy     <= busy_next;
    end
  end

  assign m_tdata = {6'b0, out_busy, out_accepted, out_sample};

endmodule
